@@ hdl/dsdc_pkg.sv @@
// Shared types, constants and calendar helper functions for the date span day counter.
// No dependencies; every module of the block imports this package.

package dsdc_pkg;

    // largest accepted year
    localparam int unsigned YEAR_MAX = 9999;

    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [13:0] year_t;
    typedef logic [21:0] count_t;
    typedef logic [2:0]  wday_t;

    // year first so that a packed compare orders dates on the calendar
    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_WEEKEND_MASK = 1'b0,
        REG_INCLUDE_END  = 1'b1
    } cfg_index_t;

    // one result word
    typedef struct packed {
        count_t total;
        count_t business;
        wday_t  start_wd;
        wday_t  end_wd;
        logic   status;
    } result_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    // request into the weekday unit
    typedef struct packed {
        logic  valid;
        logic  tag;
        date_t date;
    } wd_req_t;

    // response from the weekday unit
    typedef struct packed {
        logic  valid;
        logic  tag;
        wday_t wd;
    } wd_rsp_t;

    // floor(x / 25) for x below 4096, reciprocal multiply
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd5243;
        return p[24:17];
    endfunction

    // gregorian leap-year rule
    function automatic logic leap_year(input year_t y);
        logic [7:0]  c;
        logic [14:0] c100;
        logic        div100;
        c      = div25(y[13:2]);
        c100   = 15'(c) * 15'd100;
        div100 = (c100 == {1'b0, y});
        return ((y[1:0] == 2'd0) && !div100) || (div100 && (c[1:0] == 2'd0));
    endfunction

    // days in a month, zero for a month code outside the year
    function automatic day_t month_len(input month_t m, input year_t y);
        day_t len;
        case (m)
            4'd2:                           len = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:        len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                   len = 5'd31;
            default:                        len = 5'd0;
        endcase
        return len;
    endfunction

    // date range check
    function automatic logic date_ok(input date_t dt);
        logic y_ok;
        logic m_ok;
        y_ok = (dt.year != '0) && (dt.year <= year_t'(YEAR_MAX));
        m_ok = (dt.month >= 4'd1) && (dt.month <= 4'd12);
        return y_ok && m_ok && (dt.day != '0) && (dt.day <= month_len(dt.month, dt.year));
    endfunction

    // floor(31 * mm / 12) for the shifted month mm = 1..12
    function automatic logic [4:0] month_term(input month_t mm);
        logic [4:0] t;
        case (mm)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

@@ hdl/date_span_day_counter_top.sv @@
// Usage:
//   Input channel (in_valid/in_ready) takes one word holding a start and an end date.
//   Output channel (out_valid/out_ready) returns one word per input word: day count,
//   business-day count, both weekdays (0 = Sunday) and a status bit for a bad date.
//   Configuration port: cfg_we with cfg_index 0 writes the weekend mask, index 1 the
//   include-end-day bit; write only while the block is idle.
// Timing:
//   the day-stepping loop in the sequencer advances one calendar day per cycle, so a result
//   takes longer the more days lie from start to end; a start not before the end steps no
//   days, and a bad date skips the weekday unit and the loop. The next word is taken in the
//   cycle after the previous result has moved to the output register; no new word is taken
//   while one is in progress.
// Reset:
//   clears all control state; the weekend mask returns to Friday and Saturday and the
//   end day is not counted.
// Stall:
//   when out_ready is low the result holds in the output register; the block can
//   still finish one more word and then waits with in_ready low.
// Depends on dsdc_pkg, dsdc_seq, dsdc_wday.

module date_span_day_counter_top
    import dsdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] start_day,
    input  logic [3:0] start_month,
    input  logic [13:0] start_year,
    input  logic [4:0] end_day,
    input  logic [3:0] end_month,
    input  logic [13:0] end_year,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [21:0] total_days,
    output logic [21:0] business_days,
    output logic [2:0] start_weekday,
    output logic [2:0] end_weekday,
    output logic       status,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [6:0] cfg_data
);

    logic [6:0] weekend_mask_reg;
    logic       include_end_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    seq_stat_t  stat;
    result_t    seq_res;
    date_t      sdate;
    date_t      edate;
    logic       accept;
    logic       load;

    assign sdate    = '{year: start_year, month: start_month, day: start_day};
    assign edate    = '{year: end_year, month: end_month, day: end_day};
    assign in_ready = stat.idle;
    assign accept   = in_valid && stat.idle;
    assign load     = stat.done && (!out_valid_reg || out_ready);

    dsdc_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .start_date      (sdate),
        .end_date        (edate),
        .weekend_mask    (weekend_mask_reg),
        .include_end_day (include_end_reg),
        .res_take        (load),
        .stat            (stat),
        .res             (seq_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weekend_mask_reg <= 7'd96;
            include_end_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WEEKEND_MASK: weekend_mask_reg <= cfg_data;
                REG_INCLUDE_END:  include_end_reg  <= cfg_data[0];
                default:          weekend_mask_reg <= weekend_mask_reg;
            endcase
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= seq_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign total_days    = out_reg.total;
    assign business_days = out_reg.business;
    assign start_weekday = out_reg.start_wd;
    assign end_weekday   = out_reg.end_wd;
    assign status        = out_reg.status;

endmodule

@@ hdl/dsdc_wday.sv @@
// Two-stage weekday unit, 0 = Sunday, shared by the start and end dates.
// Depends on dsdc_pkg.

module dsdc_wday
    import dsdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  wd_req_t req,
    output wd_rsp_t rsp
);

    logic        v1_reg;
    logic        tag1_reg;
    logic [14:0] sum_reg;
    logic        v2_reg;
    logic        tag2_reg;
    wday_t       wd_reg;

    logic        a;
    year_t       yy;
    month_t      mm;
    logic [7:0]  q100;
    logic [14:0] sum_next;
    logic [30:0] prod;
    logic [12:0] q7;
    logic [14:0] rem;

    // stage one: day sum of the weekday formula
    always_comb
    begin
        a        = (req.date.month <= 4'd2);
        yy       = req.date.year - year_t'(a);
        mm       = a ? (req.date.month + 4'd10) : (req.date.month - 4'd2);
        q100     = div25(yy[13:2]);
        sum_next = 15'(req.date.day) + 15'(yy) + 15'(yy[13:2]) - 15'(q100)
                   + 15'(q100[7:2]) + 15'(month_term(mm));
    end

    // stage two: modulo seven by reciprocal multiply
    always_comb
    begin
        prod = 31'(sum_reg) * 31'd37450;
        q7   = prod[30:18];
        rem  = sum_reg - 15'(q7) * 15'd7;
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        tag1_reg <= req.tag;
        sum_reg  <= sum_next;
        tag2_reg <= tag1_reg;
        wd_reg   <= rem[2:0];
    end

    assign rsp.valid = v2_reg;
    assign rsp.tag   = tag2_reg;
    assign rsp.wd    = wd_reg;

`ifndef SYNTHESIS
    a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (wd_reg <= 3'd6))
        else $error("weekday out of range");
    a_pipe_valid: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg)
        else $error("weekday stage lost a word");
    a_pipe_tag: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> (tag2_reg == $past(tag1_reg)))
        else $error("weekday tag mixed up");
`endif

endmodule

@@ hdl/dsdc_seq.sv @@
// Sequencer: checks both dates; if valid, runs the weekday unit and steps one day per cycle.
// Depends on dsdc_pkg and dsdc_wday.

module dsdc_seq
    import dsdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  date_t     start_date,
    input  date_t     end_date,
    input  logic [6:0] weekend_mask,
    input  logic      include_end_day,
    input  logic      res_take,
    output seq_stat_t stat,
    output result_t   res
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_WD_END = 6'b000100,
        S_WAIT   = 6'b001000,
        S_STEP   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    date_t   sdate_reg, edate_reg;
    date_t   cur_reg, cur_next;
    wday_t   cur_wd_reg, cur_wd_next;
    wday_t   start_wd_reg, start_wd_next;
    wday_t   end_wd_reg, end_wd_next;
    count_t  total_reg, total_next;
    count_t  bus_reg, bus_next;
    logic    status_reg, status_next;
    wd_req_t wreq;
    wd_rsp_t wrsp;
    day_t    mlen;
    logic    dates_ok;

    dsdc_wday u_wday (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .rsp   (wrsp)
    );

    assign mlen     = month_len(cur_reg.month, cur_reg.year);
    assign dates_ok = date_ok(sdate_reg) && date_ok(edate_reg);

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cur_wd_next   = cur_wd_reg;
        start_wd_next = start_wd_reg;
        end_wd_next   = end_wd_reg;
        total_next    = total_reg;
        bus_next      = bus_reg;
        status_next   = status_reg;
        wreq.valid    = 1'b0;
        wreq.tag      = 1'b0;
        wreq.date     = sdate_reg;

        // weekday results come back in issue order
        if (wrsp.valid)
        begin
            if (wrsp.tag)
            begin
                end_wd_next = wrsp.wd;
            end
            else
            begin
                start_wd_next = wrsp.wd;
                cur_wd_next   = wrsp.wd;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                total_next    = '0;
                bus_next      = '0;
                start_wd_next = '0;
                end_wd_next   = '0;
                cur_next      = sdate_reg;
                status_next   = !dates_ok;
                if (dates_ok)
                begin
                    wreq.valid = 1'b1;
                    state_next = S_WD_END;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WD_END:
            begin
                wreq.valid = 1'b1;
                wreq.tag   = 1'b1;
                wreq.date  = edate_reg;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (wrsp.valid && wrsp.tag)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (cur_reg < edate_reg)
                begin
                    total_next  = total_reg + count_t'(1);
                    bus_next    = bus_reg + count_t'(!weekend_mask[cur_wd_reg]);
                    cur_wd_next = (cur_wd_reg == 3'd6) ? 3'd0 : (cur_wd_reg + 3'd1);
                    // advance one calendar day
                    if (cur_reg.day == mlen)
                    begin
                        cur_next.day = 5'd1;
                        if (cur_reg.month == 4'd12)
                        begin
                            cur_next.month = 4'd1;
                            cur_next.year  = cur_reg.year + year_t'(1);
                        end
                        else
                        begin
                            cur_next.month = cur_reg.month + 4'd1;
                        end
                    end
                    else
                    begin
                        cur_next.day = cur_reg.day + 5'd1;
                    end
                end
                else
                begin
                    total_next = total_reg + count_t'(include_end_day);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            sdate_reg <= start_date;
            edate_reg <= end_date;
        end
        cur_reg      <= cur_next;
        cur_wd_reg   <= cur_wd_next;
        start_wd_reg <= start_wd_next;
        end_wd_reg   <= end_wd_next;
        total_reg    <= total_next;
        bus_reg      <= bus_next;
        status_reg   <= status_next;
    end

    assign stat.idle    = (state_reg == S_IDLE);
    assign stat.done    = (state_reg == S_DONE);
    assign res.total    = total_reg;
    assign res.business = bus_reg;
    assign res.start_wd = start_wd_reg;
    assign res.end_wd   = end_wd_reg;
    assign res.status   = status_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_bus_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (bus_reg <= total_reg))
        else $error("business days exceed total days");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && status_reg) |->
            ((total_reg == '0) && (start_wd_reg == '0) && (end_wd_reg == '0)))
        else $error("invalid date gave nonzero result");
`endif

endmodule

@@ bench/date_span_day_counter_top_test.sv @@
// Self-checking bench for date_span_day_counter_top: a directed table of date pairs, then
// random pairs over several weekend-mask and end-day settings and idle patterns.
// Depends on dsdc_pkg and the block's RTL; results come from a calendar model kept here or from typed rows.

module date_span_day_counter_top_test;
    import dsdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int unsigned CHUNK_WORDS  = 119;
    localparam int unsigned CHUNKS       = 8;
    localparam int unsigned DRAIN_CYCLES = 20;

    // one stimulus row; answer is used only when typed is set
    typedef struct {
        date_t   from_date;
        date_t   to_date;
        bit      typed;
        result_t answer;
    } span_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    date_t       from_drv;
    date_t       to_drv;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [21:0] total_days;
    logic [21:0] business_days;
    logic [2:0]  start_weekday;
    logic [2:0]  end_weekday;
    logic        status;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    // local copy of the block's registers
    logic [6:0]  weekend_bits;
    logic        count_end_day;

    result_t     expected_counts[$];
    span_row_t   span_table[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    date_span_day_counter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_day     (from_drv.day),
        .start_month   (from_drv.month),
        .start_year    (from_drv.year),
        .end_day       (to_drv.day),
        .end_month     (to_drv.month),
        .end_year      (to_drv.year),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_days    (total_days),
        .business_days (business_days),
        .start_weekday (start_weekday),
        .end_weekday   (end_weekday),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- calendar model ----------------

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            2:                       len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:             len = 30;
            1, 3, 5, 7, 8, 10, 12:   len = 31;
            default:                 len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_valid(input date_t dt);
        int unsigned len;
        len = days_in_month(dt.month, dt.year);
        return (dt.year >= 1) && (dt.year <= YEAR_MAX) && (len != 0)
            && (dt.day >= 1) && (dt.day <= len);
    endfunction

    // days since a fixed origin, year taken to start in March
    function automatic int unsigned day_serial(input date_t dt);
        int unsigned yy;
        int unsigned mp;
        yy = dt.year - ((dt.month <= 2) ? 1 : 0);
        mp = (dt.month + 9) % 12;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + dt.day - 1;
    endfunction

    // expected counts and weekdays for one date pair; origin offset 3 makes 1 Jan 1 a Monday
    function automatic result_t span_counts(input date_t a, input date_t b);
        result_t     r;
        int unsigned sa;
        int unsigned sb;
        int unsigned span;
        int unsigned total;
        int unsigned biz;
        r     = '0;
        total = 0;
        biz   = 0;
        if (!date_valid(a) || !date_valid(b))
        begin
            r.status = 1'b1;
        end
        else
        begin
            sa         = day_serial(a);
            sb         = day_serial(b);
            r.start_wd = wday_t'((sa + 3) % 7);
            r.end_wd   = wday_t'((sb + 3) % 7);
            if (sa < sb)
            begin
                span = sb - sa;
                biz  = (span / 7) * (7 - $countones(weekend_bits));
                for (int unsigned k = 0; k < span % 7; k++)
                begin
                    if (!weekend_bits[(sa + 3 + k) % 7])
                        biz++;
                end
                total = span;
            end
            total      = total + count_end_day;
            r.total    = count_t'(total);
            r.business = count_t'(biz);
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // mostly any year, often the first and last years and century years
    function automatic year_t pick_year();
        year_t y;
        case ($urandom_range(9))
            0:       y = year_t'($urandom_range(1, 3));
            1:       y = year_t'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
            2:       y = year_t'(100 * $urandom_range(1, 99));
            default: y = year_t'($urandom_range(1, YEAR_MAX));
        endcase
        return y;
    endfunction

    // valid date in a given year, leaning toward month ends
    function automatic date_t random_date_in(input year_t y);
        date_t       d;
        int unsigned len;
        d.year  = y;
        d.month = month_t'($urandom_range(1, 12));
        len     = days_in_month(d.month, y);
        d.day   = ($urandom_range(7) == 0) ? day_t'(len) : day_t'($urandom_range(1, len));
        return d;
    endfunction

    // one random date pair; spans kept mostly within a year or two
    task automatic make_random_pair(output date_t a, output date_t b);
        int unsigned pick;
        int unsigned gap;
        int unsigned len;
        date_t       t;
        pick = $urandom_range(99);
        a    = random_date_in(pick_year());
        if (pick < 12)
        begin
            // raw field noise, long valid spans pulled back into one year
            a.day   = day_t'($urandom);
            a.month = month_t'($urandom);
            a.year  = year_t'($urandom);
            b.day   = day_t'($urandom);
            b.month = month_t'($urandom);
            b.year  = year_t'($urandom);
            if (date_valid(a) && date_valid(b) && (b.year > a.year + 1))
                b.year = a.year;
        end
        else if (pick < 18)
        begin
            // well-formed pair with one field broken
            b = random_date_in(a.year);
            case ($urandom_range(5))
                0: a.day = day_t'(0);
                1: a.month = $urandom_range(1) ? month_t'(0) : month_t'($urandom_range(13, 15));
                2: a.year = $urandom_range(1) ? year_t'(0)
                                              : year_t'($urandom_range(YEAR_MAX + 1, 16383));
                3:
                begin
                    len   = days_in_month(b.month, b.year);
                    b.day = (len == 31) ? day_t'(0) : day_t'($urandom_range(len + 1, 31));
                end
                4: b.month = $urandom_range(1) ? month_t'(0) : month_t'($urandom_range(13, 15));
                default: b.year = $urandom_range(1) ? year_t'(0)
                                                    : year_t'($urandom_range(YEAR_MAX + 1, 16383));
            endcase
        end
        else if (pick < 24)
        begin
            // start on or after the end
            if ($urandom_range(2) == 0)
                b = a;
            else
                b = random_date_in(a.year);
            if (day_serial(b) > day_serial(a))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
        else
        begin
            // ordinary span, a few of them several years long
            gap = (pick < 26) ? $urandom_range(2, 8) : $urandom_range(1);
            b   = random_date_in(year_t'((a.year + gap > YEAR_MAX) ? YEAR_MAX : a.year + gap));
            if (day_serial(b) < day_serial(a))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
    endtask

    task automatic add_row(input int sd, input int sm, input int sy,
                           input int ed, input int em, input int ey,
                           input bit typed = 1'b0, input int tot = 0, input int biz = 0,
                           input int sw = 0, input int ew = 0, input int st = 0);
        span_row_t row;
        row.from_date.day    = day_t'(sd);
        row.from_date.month  = month_t'(sm);
        row.from_date.year   = year_t'(sy);
        row.to_date.day      = day_t'(ed);
        row.to_date.month    = month_t'(em);
        row.to_date.year     = year_t'(ey);
        row.typed            = typed;
        row.answer.total     = count_t'(tot);
        row.answer.business  = count_t'(biz);
        row.answer.start_wd  = wday_t'(sw);
        row.answer.end_wd    = wday_t'(ew);
        row.answer.status    = st[0];
        span_table.push_back(row);
    endtask

    // ---------------- drivers ----------------

    // present one word at a falling edge, record its expectation once taken
    task automatic send_span(input span_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        from_drv = row.from_date;
        to_drv   = row.to_date;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (row.typed)
            expected_counts.push_back(row.answer);
        else
            expected_counts.push_back(span_counts(row.from_date, row.to_date));
        @(negedge clk);
    endtask

    // write both registers back to back, block idle
    task automatic write_config(input logic [6:0] mask, input logic end_day);
        cfg_we    = 1'b1;
        cfg_index = REG_WEEKEND_MASK;
        cfg_data  = mask;
        @(negedge clk);
        cfg_index = REG_INCLUDE_END;
        cfg_data  = {6'd0, end_day};
        @(negedge clk);
        cfg_we        = 1'b0;
        weekend_bits  = mask;
        count_end_day = end_day;
    endtask

    task automatic wait_results();
        while (expected_counts.size() != 0)
            @(negedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- checking ----------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("result word with no span pending");
                error_count++;
            end
            else
            begin
                want = expected_counts.pop_front();
                check_field("total_days", want.total, total_days);
                check_field("business_days", want.business, business_days);
                check_field("start_weekday", want.start_wd, start_weekday);
                check_field("end_weekday", want.end_wd, end_weekday);
                check_field("status", want.status, status);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        span_row_t row;
        date_t     a;
        date_t     b;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        from_drv       = '0;
        to_drv         = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_WEEKEND_MASK;
        cfg_data       = '0;
        weekend_bits   = 7'd96;
        count_end_day  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // directed table, reset settings: Friday and Saturday off, end day not counted
        // bad dates: every count and weekday zero, status set
        add_row( 0,  1,  2000,  1,  1,  2000, 1, 0, 0, 0, 0, 1);
        add_row( 1,  0,  2000,  1,  1,  2000, 1, 0, 0, 0, 0, 1);
        add_row( 1, 15,  2000,  1,  1,  2000, 1, 0, 0, 0, 0, 1);
        add_row( 1, 13,  2000,  1,  1,  2000, 1, 0, 0, 0, 0, 1);
        add_row( 1,  1,     0,  1,  1,  2000, 1, 0, 0, 0, 0, 1);
        add_row( 1,  1,  2000,  1,  1, 16383, 1, 0, 0, 0, 0, 1);
        add_row( 1,  1,  2000,  1,  1, 10000, 1, 0, 0, 0, 0, 1);
        add_row(31,  4,  2021,  1,  5,  2021, 1, 0, 0, 0, 0, 1);
        add_row(29,  2,  1900,  1,  3,  1900, 1, 0, 0, 0, 0, 1);
        add_row(29,  2,  2023,  1,  3,  2023, 1, 0, 0, 0, 0, 1);
        add_row( 1,  1,  2000,  0,  1,  2000, 1, 0, 0, 0, 0, 1);
        // same date, a Saturday
        add_row( 1,  1,  2000,  1,  1,  2000, 1, 0, 0, 6, 6, 0);
        // last date before first date: Friday and Monday reported, counts zero
        add_row(31, 12,  9999,  1,  1,     1, 1, 0, 0, 5, 1, 0);
        // one full week from the first date
        add_row( 1,  1,     1,  8,  1,     1, 1, 7, 5, 1, 1, 0);
        // leap days, century rule, year and month rollovers
        add_row(31, 12,  2000, 31,  1,  2000);
        add_row(25, 12,  9999, 31, 12,  9999);
        add_row(29,  2,  2000,  1,  3,  2000);
        add_row(29,  2,  2024, 29,  3,  2024);
        add_row( 1,  2,  1900,  1,  3,  1900);
        add_row(31, 12,  1999,  1,  1,  2000);
        add_row( 1,  1,  2000,  1,  1,  2001);
        add_row(15,  6,  2400, 15,  6,  2401);
        add_row(30, 11,  2099,  1,  3,  2100);
        add_row( 1,  1,     1, 31,  1,     1);
        add_row(31,  1,  9999, 31, 12,  9999);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (span_table[i])
            send_span(span_table[i]);
        in_valid = 1'b0;
        wait_results();

        // random phases, each writing a register setting and using one of four idle patterns
        for (int unsigned c = 0; c < CHUNKS; c++)
        begin
            case (c)
                0:       write_config(7'd96, 1'b0);
                1:       write_config(7'd0, 1'b1);
                2:       write_config(7'd127, 1'b0);
                3:       write_config(7'd65, 1'b1);
                5:       write_config(7'd127, 1'b1);
                default: write_config(7'($urandom), 1'($urandom));
            endcase
            case (c % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            repeat (CHUNK_WORDS)
            begin
                make_random_pair(a, b);
                row.from_date = a;
                row.to_date   = b;
                row.typed     = 1'b0;
                row.answer    = '0;
                send_span(row);
            end
            in_valid = 1'b0;
            wait_results();
        end

        // let any stray word show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ date_span_day_counter_top.f @@
hdl/dsdc_pkg.sv
hdl/dsdc_wday.sv
hdl/dsdc_seq.sv
hdl/date_span_day_counter_top.sv
bench/date_span_day_counter_top_test.sv
